// ===== rtl/gru_pkg.sv =====
// Shared types and constants for the glyph row integer upscaler.
package gru_pkg;

  localparam int unsigned PixBits       = 2;
  localparam int unsigned MaxGlyphWidth = 8;
  localparam int unsigned MaxScale      = 4;
  localparam int unsigned SrcRowW       = PixBits * MaxGlyphWidth;
  localparam int unsigned OutRowW       = 64;
  localparam int unsigned OutCols       = OutRowW / PixBits;
  localparam int unsigned ColW          = $clog2(OutCols);
  localparam int unsigned RepW          = $clog2(MaxScale);
  localparam int unsigned WidthW        = 4;
  localparam int unsigned ScaleW        = 3;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 4;
  localparam int unsigned OutTdataW     = ((OutRowW + RepW + 7) / 8) * 8;

  typedef enum logic [CfgIdxW-1:0] {
    RegGlyphWidth  = 2'd0,
    RegScaleFactor = 2'd1
  } cfg_reg_e;

  // Configuration after clamping, as used by the datapath.
  typedef struct packed {
    logic [WidthW-1:0] width;
    logic [ScaleW-1:0] scale;
  } eff_cfg_t;

endpackage

// ===== rtl/glyph_row_integer_upscaler_core.sv =====
// Top level of the glyph row integer upscaler.
//
// Source glyph rows (2 bits per pixel, column 0 in the top bits) arrive on the
// s_axis channel, with tlast marking the last source row of a glyph. Each row is
// widened horizontally by the scale factor and sent on m_axis scale times, one
// copy per cycle while the receiver is ready, giving the vertical repeat. m_axis_tlast
// marks the last copy of a row, and m_axis_tuser the last copy of the last row of a glyph.
// The cfg channel writes glyph width (index 0) and scale factor (index 1); it is
// always ready and should only be used while the block is idle.
// An item passes an input register and then the result register before its first
// copy is offered. The result register holds one row until all scale copies
// (one to four) are taken, and only then loads the next item. The input register
// takes the next item while copies are still being sent. When the receiver stalls,
// the current copy is held and the input side fills and then drops tready. Reset
// empties both registers and sets width 8, scale 1.
module glyph_row_integer_upscaler_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gru_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [gru_pkg::CfgDataW-1:0]      cfg_data_i,
  // Source rows.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gru_pkg::SrcRowW-1:0]       s_axis_tdata,  // [15:0] source_row
  input  logic                              s_axis_tlast,
  // Scaled rows.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gru_pkg::OutTdataW-1:0]     m_axis_tdata,  // [63:0] scaled_row, [65:64] repeat_index
  output logic                              m_axis_tlast,
  output logic                              m_axis_tuser   // [0] glyph_end
);
  import gru_pkg::*;

  eff_cfg_t           eff_cfg;
  logic               in_valid_q;
  logic [SrcRowW-1:0] in_row_q;
  logic               in_last_q;
  logic               out_free;
  logic               load_out;
  logic [OutRowW-1:0] wide_row;
  logic [OutRowW-1:0] out_row;
  logic [RepW-1:0]    out_rep;

  gru_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .eff_cfg_o   (eff_cfg)
  );

  assign load_out      = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_row_q  <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  gru_widen u_widen (
    .src_i (in_row_q),
    .cfg_i (eff_cfg),
    .row_o (wide_row)
  );

  gru_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load_out),
    .row_i        (wide_row),
    .glyph_last_i (in_last_q),
    .scale_i      (eff_cfg.scale),
    .ready_i      (m_axis_tready),
    .free_o       (out_free),
    .valid_o      (m_axis_tvalid),
    .row_o        (out_row),
    .rep_o        (out_rep),
    .run_end_o    (m_axis_tlast),
    .glyph_end_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {(OutTdataW - OutRowW - RepW)'(0), out_rep, out_row};

  // A glyph can only end on the last copy of a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("glyph end without run end");

  // The copy counter never passes the scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, out_rep} < eff_cfg.scale))
    else $error("repeat index beyond scale");

  // The input side only stalls while a row waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && m_axis_tvalid)
    else $error("input stalled with nothing pending");

  // A copy that is not the last is followed by the next copy of the same row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (out_rep == $past(out_rep) + RepW'(1)) && $stable(out_row))
    else $error("vertical repeat broken");

endmodule

// ===== rtl/gru_cfg_regs.sv =====
// Configuration registers with clamping of glyph width and scale.
module gru_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gru_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gru_pkg::CfgDataW-1:0]   cfg_data_i,
  output gru_pkg::eff_cfg_t              eff_cfg_o
);
  import gru_pkg::*;

  logic [WidthW-1:0] width_q;
  logic [ScaleW-1:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthW'(MaxGlyphWidth);
      scale_q <= ScaleW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGlyphWidth:  width_q <= cfg_data_i[WidthW-1:0];
        RegScaleFactor: scale_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_cfg_o.width = (width_q > WidthW'(MaxGlyphWidth)) ? WidthW'(MaxGlyphWidth) : width_q;
    if (scale_q == '0) begin
      eff_cfg_o.scale = ScaleW'(1);
    end else if (scale_q > ScaleW'(MaxScale)) begin
      eff_cfg_o.scale = ScaleW'(MaxScale);
    end else begin
      eff_cfg_o.scale = scale_q;
    end
  end

endmodule

// ===== rtl/gru_widen.sv =====
// Horizontal widening: each source pixel is copied scale times across the row.
module gru_widen (
  input  logic [gru_pkg::SrcRowW-1:0] src_i,
  input  gru_pkg::eff_cfg_t           cfg_i,
  output logic [gru_pkg::OutRowW-1:0] row_o
);
  import gru_pkg::*;

  always_comb begin
    logic [ColW-1:0]    col;
    logic [PixBits-1:0] pix;
    row_o = '0;
    for (int x = 0; x < int'(MaxGlyphWidth); x++) begin
      pix = src_i[SrcRowW-1-PixBits*x -: PixBits];
      for (int d = 0; d < int'(MaxScale); d++) begin
        col = ColW'(x * int'(cfg_i.scale) + d);
        if ((WidthW'(x) < cfg_i.width) && (ScaleW'(d) < cfg_i.scale)) begin
          row_o[OutRowW-1-PixBits*int'(col) -: PixBits] = pix;
        end
      end
    end
  end

endmodule

// ===== rtl/gru_out_stage.sv =====
// Result register that repeats one widened row scale times.
module gru_out_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [gru_pkg::OutRowW-1:0]  row_i,
  input  logic                         glyph_last_i,
  input  logic [gru_pkg::ScaleW-1:0]   scale_i,
  input  logic                         ready_i,
  output logic                         free_o,
  output logic                         valid_o,
  output logic [gru_pkg::OutRowW-1:0]  row_o,
  output logic [gru_pkg::RepW-1:0]     rep_o,
  output logic                         run_end_o,
  output logic                         glyph_end_o
);
  import gru_pkg::*;

  logic               valid_q;
  logic [OutRowW-1:0] row_q;
  logic               last_q;
  logic [RepW-1:0]    rep_q;
  logic               run_end;

  assign run_end     = (rep_q == RepW'(scale_i - ScaleW'(1)));
  assign free_o      = !valid_q || (ready_i && run_end);
  assign valid_o     = valid_q;
  assign row_o       = row_q;
  assign rep_o       = rep_q;
  assign run_end_o   = run_end;
  assign glyph_end_o = run_end && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rep_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      rep_q   <= '0;
    end else if (valid_q && ready_i) begin
      if (run_end) begin
        valid_q <= 1'b0;
      end else begin
        rep_q <= rep_q + RepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q  <= row_i;
      last_q <= glyph_last_i;
    end
  end

endmodule

// ===== dv/upscaled_row_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the scaled rows of the glyph row upscaler and compares them.
module upscaled_row_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [gru_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gru_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [gru_pkg::SrcRowW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [gru_pkg::OutTdataW-1:0] m_axis_tdata,
  input  logic                          m_axis_tlast,
  input  logic                          m_axis_tuser,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   rows_owed_o
);
  import gru_pkg::*;

  typedef struct {
    logic [OutRowW-1:0] row;
    logic [RepW-1:0]    rep;
    logic               run_end;
    logic               glyph_end;
  } scaled_copy_t;

  logic [WidthW-1:0] glyph_width_q;
  logic [ScaleW-1:0] scale_q;
  scaled_copy_t      owed_rows[$];
  scaled_copy_t      want;
  logic [OutRowW-1:0] widened;
  int unsigned       copies;
  int unsigned       mismatches;

  function automatic int unsigned used_width(logic [WidthW-1:0] w);
    if (w > MaxGlyphWidth) return MaxGlyphWidth;
    return w;
  endfunction

  function automatic int unsigned used_scale(logic [ScaleW-1:0] s);
    if (s == 0) return 1;
    if (s > MaxScale) return MaxScale;
    return s;
  endfunction

  // Each source pixel is copied s times across the row, column 0 at the top bits.
  function automatic logic [OutRowW-1:0] widen_source_row(logic [SrcRowW-1:0] src,
                                                          int unsigned w, int unsigned s);
    logic [OutRowW-1:0] acc;
    logic [PixBits-1:0] pix;
    acc = '0;
    for (int unsigned x = 0; x < w; x++) begin
      pix = src[SrcRowW - 1 - PixBits * x -: PixBits];
      for (int unsigned d = 0; d < s; d++) begin
        acc[OutRowW - 1 - PixBits * (x * s + d) -: PixBits] = pix;
      end
    end
    return acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_width_q = WidthW'(MaxGlyphWidth);
      scale_q       = ScaleW'(1);
      owed_rows.delete();
      mismatches    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegGlyphWidth) begin
          glyph_width_q = cfg_data_i[WidthW-1:0];
        end else if (cfg_index_i == RegScaleFactor) begin
          scale_q = cfg_data_i[ScaleW-1:0];
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_rows.size() == 0) begin
          $error("unexpected scaled row %h", m_axis_tdata[OutRowW-1:0]);
          mismatches++;
        end else begin
          want = owed_rows.pop_front();
          if (m_axis_tdata[OutRowW-1:0] !== want.row) begin
            $error("scaled_row: expected %h, got %h", want.row, m_axis_tdata[OutRowW-1:0]);
            mismatches++;
          end
          if (m_axis_tdata[OutRowW +: RepW] !== want.rep) begin
            $error("repeat_index: expected %0d, got %0d", want.rep,
                   m_axis_tdata[OutRowW +: RepW]);
            mismatches++;
          end
          if (m_axis_tlast !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tuser !== want.glyph_end) begin
            $error("glyph_end: expected %0b, got %0b", want.glyph_end, m_axis_tuser);
            mismatches++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        copies  = used_scale(scale_q);
        widened = widen_source_row(s_axis_tdata, used_width(glyph_width_q), copies);
        for (int unsigned k = 0; k < copies; k++) begin
          want.row       = widened;
          want.rep       = RepW'(k);
          want.run_end   = (k + 1 == copies);
          want.glyph_end = (k + 1 == copies) && s_axis_tlast;
          owed_rows.push_back(want);
        end
      end
    end
    mismatch_count_o <= mismatches;
    rows_owed_o      <= owed_rows.size();
  end

endmodule

// ===== dv/tb_glyph_row_integer_upscaler_core.sv =====
`timescale 1ns / 1ps
// Testbench top: drives source rows and register writes into the upscaler and gives the verdict.
module tb_glyph_row_integer_upscaler_core;
  import gru_pkg::*;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdlePercent   = 18;
  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SrcRowW-1:0]   s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;

  int unsigned mismatch_count;
  int unsigned rows_owed;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  bit          tx_steady   = 1'b0;
  bit          rx_steady   = 1'b0;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;

  glyph_row_integer_upscaler_core dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  upscaled_row_checker checker_i (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser,
    .mismatch_count_o (mismatch_count),
    .rows_owed_o      (rows_owed)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, steady stretches, and one long hold-off that fills the block.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left     <= HoldOffCycles;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_steady || ($urandom_range(99) >= IdlePercent);
    end
  end

  task automatic send_row(input logic [SrcRowW-1:0] src, input logic last);
    if (!tx_steady) begin
      while ($urandom_range(99) < IdlePercent) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= src;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops the source and waits until every owed row has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rows_owed != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_shape(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] s);
    write_reg(RegGlyphWidth, w);
    write_reg(RegScaleFactor, s);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_rows(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_row(SrcRowW'($urandom), $urandom_range(3) == 0);
    end
    drain();
  endtask

  initial begin
    logic [CfgDataW-1:0] w_pick;
    logic [CfgDataW-1:0] s_pick;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Shape after reset: eight pixels wide, no magnification.
    send_row(16'h0000, 1'b0);
    send_row(16'hFFFF, 1'b0);
    send_row(16'hE4E4, 1'b1);
    drain();

    // Widest output row: 8 pixels times 4.
    set_shape(4'd8, 4'd4);
    send_row(16'hFFFF, 1'b0);
    send_row(16'h1B1B, 1'b1);
    send_row(16'hA55A, 1'b0);
    drain();

    // Single pixel; the bits past the width must be ignored.
    set_shape(4'd1, 4'd4);
    send_row(16'hC000, 1'b1);
    send_row(16'h3FFF, 1'b0);
    drain();
    set_shape(4'd1, 4'd1);
    send_row(16'h8000, 1'b1);
    drain();

    // A zero width still gives the usual copies, all blank.
    set_shape(4'd0, 4'd2);
    send_row(16'hFFFF, 1'b1);
    drain();

    // Oversized width and scale saturate.
    set_shape(4'd15, 4'd7);
    send_row(16'hD2B4, 1'b0);
    send_row(16'hFFFF, 1'b1);
    drain();

    // Scale zero behaves as one.
    set_shape(4'd9, 4'd0);
    send_row(16'h0F0F, 1'b1);
    drain();

    // The top bit of the scale data is dropped by the three-bit register.
    set_shape(4'd5, 4'hC);
    send_row(16'hFFFF, 1'b0);
    send_row(16'h2468, 1'b1);
    drain();

    // Writes to unused indexes must leave the shape alone.
    write_reg(RegSpare2, 4'h3);
    write_reg(RegSpare3, 4'hF);
    cfg_valid_i <= 1'b0;
    send_row(16'h9999, 1'b1);
    drain();

    for (int unsigned p = 0; p < 12; p++) begin
      tx_steady = (p == 3);
      rx_steady <= (p == 3);
      if (p == 7) begin
        hold_req <= 1'b1;
      end
      w_pick = ($urandom_range(4) == 0) ? CfgDataW'($urandom_range(15))
                                        : CfgDataW'($urandom_range(1, 8));
      s_pick = ($urandom_range(4) == 0) ? CfgDataW'($urandom_range(15))
                                        : CfgDataW'($urandom_range(1, 4));
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? RegSpare2 : RegSpare3, CfgDataW'($urandom));
      end
      set_shape(w_pick, s_pick);
      random_rows(40);
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gru_pkg.sv
rtl/gru_cfg_regs.sv
rtl/gru_widen.sv
rtl/gru_out_stage.sv
rtl/glyph_row_integer_upscaler_core.sv
dv/upscaled_row_checker.sv
dv/tb_glyph_row_integer_upscaler_core.sv
